FILE: rtl/smf_pkg.sv
// Package: window size, widths, stored entry layout, RAM port bundle and FSM states.
`default_nettype none
package smf_pkg;

  localparam int WINDOW   = 15;
  localparam int SAMPLE_W = 12;
  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int RANK     = WINDOW / 2;

  // each slot keeps its sample and its rank counts within the current window
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [CNT_W-1:0]    gt;   // entries strictly greater
    logic [CNT_W-1:0]    eq;   // entries equal, itself included
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/smf_sample_if.sv
// Input channel: one converter sample per word.
`default_nettype none
interface smf_sample_if;
  logic                         valid;
  logic                         ready;
  logic [smf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/smf_filtered_if.sv
// Output channel: one filtered value per word.
`default_nettype none
interface smf_filtered_if;
  logic                         valid;
  logic                         ready;
  logic [smf_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface
`default_nettype wire

FILE: rtl/smf_window_ram.sv
// Window store: one write and one registered read per cycle.
`default_nettype none
module smf_window_ram (
  input  wire logic              clk,
  input  wire smf_pkg::ram_req_t req,
  output smf_pkg::entry_t        rd_data
);

  smf_pkg::entry_t mem [smf_pkg::WINDOW];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sliding_median_filter_top.sv
// Sliding median filter: circular window in RAM, each slot carrying its rank counts.
// Pacing: one sample at a time; a new one is accepted only back in idle, the pace being set
//   by the scan that reads and rewrites every slot of the window through the RAM.
// Result: registered at the write step after the scan, or in the out step if output is held.
// Reset: synchronous, active high; clears state, fill count, head, read valid and output valid.
// The RAM needs no clearing: a slot is read only after it has been written.
`default_nettype none
module sliding_median_filter_top (
  input  wire logic      clk,
  input  wire logic      rst,
  smf_sample_if.sink     samples,
  smf_filtered_if.source results
);

  localparam int SUM_W = smf_pkg::CNT_W + 1;
  localparam logic [SUM_W-1:0] RANK_S = SUM_W'(smf_pkg::RANK);
  localparam logic [smf_pkg::CNT_W-1:0] FULL_CNT = smf_pkg::CNT_W'(smf_pkg::WINDOW);
  localparam logic [smf_pkg::IDX_W-1:0] LAST_IDX = smf_pkg::IDX_W'(smf_pkg::WINDOW - 1);

  smf_pkg::state_t state, state_next;

  logic [smf_pkg::CNT_W-1:0]    fill;
  logic [smf_pkg::IDX_W-1:0]    head;
  logic [smf_pkg::CNT_W-1:0]    k;
  logic [smf_pkg::SAMPLE_W-1:0] smp;
  logic [smf_pkg::SAMPLE_W-1:0] old;
  logic [smf_pkg::SAMPLE_W-1:0] med;
  logic [smf_pkg::SAMPLE_W-1:0] res;
  logic [smf_pkg::CNT_W-1:0]    new_gt;
  logic [smf_pkg::CNT_W-1:0]    new_eq;
  logic                         rd_v;
  logic                         rd_first;
  logic [smf_pkg::IDX_W-1:0]    rd_addr_q;
  logic                         out_v;
  logic [smf_pkg::SAMPLE_W-1:0] out_data;

  smf_pkg::ram_req_t req;
  smf_pkg::entry_t   rd_data;

  logic                         full;
  logic [smf_pkg::CNT_W-1:0]    n;
  logic                         issue;
  logic [smf_pkg::IDX_W:0]      addr_sum;
  logic [smf_pkg::IDX_W-1:0]    scan_addr;
  logic                         s_gt_e, s_eq_e, o_gt_e, o_eq_e;
  logic [SUM_W-1:0]             upd_gt, upd_eq, rank_top;
  logic                         hit;
  logic                         out_free;
  logic                         accept;
  logic [smf_pkg::IDX_W-1:0]    new_slot;
  logic [smf_pkg::SAMPLE_W-1:0] result;

  smf_window_ram u_ram (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign full     = (fill == FULL_CNT);
  assign n        = full ? FULL_CNT : fill;
  assign addr_sum = {1'b0, head} + {1'b0, k[smf_pkg::IDX_W-1:0]};
  assign scan_addr = (addr_sum >= (smf_pkg::IDX_W+1)'(smf_pkg::WINDOW)) ?
                     smf_pkg::IDX_W'(addr_sum - (smf_pkg::IDX_W+1)'(smf_pkg::WINDOW)) :
                     addr_sum[smf_pkg::IDX_W-1:0];
  assign new_slot = full ? head : fill[smf_pkg::IDX_W-1:0];
  assign result   = full ? med : smp;
  assign out_free = !out_v || results.ready;
  assign accept   = samples.valid && samples.ready;

  // counts of the slot just read, moved to the window after the swap
  assign s_gt_e   = smp > rd_data.value;
  assign s_eq_e   = smp == rd_data.value;
  assign o_gt_e   = full && (old > rd_data.value);
  assign o_eq_e   = full && (old == rd_data.value);
  assign upd_gt   = {1'b0, rd_data.gt} + SUM_W'(s_gt_e) - SUM_W'(o_gt_e);
  assign upd_eq   = {1'b0, rd_data.eq} + SUM_W'(s_eq_e) - SUM_W'(o_eq_e);
  assign rank_top = {1'b0, rd_data.gt} + {1'b0, rd_data.eq};
  assign hit      = full && ({1'b0, rd_data.gt} <= RANK_S) && (RANK_S < rank_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    issue         = 1'b0;
    req.rd_en     = 1'b0;
    req.rd_addr   = scan_addr;
    req.wr_en     = 1'b0;
    req.wr_addr   = rd_addr_q;
    req.wr_data   = '{value: rd_data.value,
                      gt: upd_gt[smf_pkg::CNT_W-1:0],
                      eq: upd_eq[smf_pkg::CNT_W-1:0]};
    case (state)
      smf_pkg::ST_IDLE: begin
        samples.ready = 1'b1;
        if (samples.valid) begin
          state_next = smf_pkg::ST_SCAN;
        end
      end
      smf_pkg::ST_SCAN: begin
        issue     = (k < n);
        req.rd_en = issue;
        // the evicted slot is overwritten later, so it is not written back
        req.wr_en = rd_v && !rd_first;
        if (!issue && !rd_v) begin
          state_next = smf_pkg::ST_WRITE;
        end
      end
      smf_pkg::ST_WRITE: begin
        req.wr_en   = 1'b1;
        req.wr_addr = new_slot;
        req.wr_data = '{value: smp, gt: new_gt, eq: new_eq};
        state_next  = out_free ? smf_pkg::ST_IDLE : smf_pkg::ST_OUT;
      end
      smf_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = smf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      head <= '0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= issue;
      if (state == smf_pkg::ST_WRITE) begin
        if (full) begin
          head <= (head == LAST_IDX) ? '0 : head + 1'b1;
        end else begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp    <= samples.sample;
      k      <= '0;
      new_gt <= '0;
      new_eq <= smf_pkg::CNT_W'(1);
    end
    if (issue) begin
      k         <= k + 1'b1;
      rd_addr_q <= scan_addr;
      rd_first  <= full && (k == '0);
    end
    if (rd_v) begin
      if (hit) begin
        med <= rd_data.value;
      end
      if (rd_first) begin
        old <= rd_data.value;
      end else begin
        new_gt <= new_gt + smf_pkg::CNT_W'(rd_data.value > smp);
        new_eq <= new_eq + smf_pkg::CNT_W'(s_eq_e);
      end
    end
    if (state == smf_pkg::ST_WRITE) begin
      res <= result;
    end
  end

  // output register, loaded straight from the write step when free, else from the out step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == smf_pkg::ST_WRITE && out_free) begin
      out_v <= 1'b1;
    end else if (state == smf_pkg::ST_OUT && out_free) begin
      out_v <= 1'b1;
    end else if (results.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == smf_pkg::ST_WRITE && out_free) begin
      out_data <= result;
    end else if (state == smf_pkg::ST_OUT && out_free) begin
      out_data <= res;
    end
  end

  assign results.valid    = out_v;
  assign results.filtered = out_data;

endmodule
`default_nettype wire
